// ===== rtl/core/fca_pkg.sv =====
`default_nettype none

package fca_pkg;

  // Rotation unit: number of iterations and internal word sizes.
  localparam int CORDIC_STEPS = 20;
  localparam int CW = 34;
  localparam int ZW = 32;

  typedef logic signed [ZW-1:0] arc_t;

  // Start amplitude 1/K in Q30.
  localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;

  // Rotation angles atan(2^-i) in units of 2^-32 turn.
  localparam arc_t ARC_TABLE [CORDIC_STEPS] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518
  };

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int HARMONIC_W = 12;
  localparam int LENGTH_W   = 4;
  localparam int CHANNEL_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_HARMONIC_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LOG2    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 2'd2;

  // Result fields.
  localparam int COEFF_W = 32;
  localparam int MEAN_W  = 16;

  // Per-item control that travels with the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } fca_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/fca_cordic_stage.sv =====
`default_nettype none

module fca_cordic_stage
  import fca_pkg::*;
#(
  parameter int STEP         = 0,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           adv_i,
  input  wire fca_ctl_t                 ctl_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic [1:0]               quad_i,
  input  wire logic signed [CW-1:0]     x_i,
  input  wire logic signed [CW-1:0]     y_i,
  input  wire logic signed [ZW-1:0]     z_i,
  output fca_ctl_t                      ctl_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  output logic [1:0]                    quad_o,
  output logic signed [CW-1:0]          x_o,
  output logic signed [CW-1:0]          y_o,
  output logic signed [ZW-1:0]          z_o
);

  fca_ctl_t                      ctl_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [1:0]                    quad_q;
  logic signed [CW-1:0]          x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ZW-1:0]          z_q, z_d;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ARC_TABLE[STEP];
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ARC_TABLE[STEP];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sample_q <= sample_i;
      quad_q   <= quad_i;
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;
  assign quad_o   = quad_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign z_o      = z_q;

endmodule

`default_nettype wire

// ===== rtl/core/fca_twiddle.sv =====
`default_nettype none

module fca_twiddle
  import fca_pkg::*;
#(
  parameter int MAX_LENGTH_LOG2 = 12,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int TWIDDLE_WIDTH   = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  adv_i,
  input  wire fca_ctl_t                        ctl_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  sample_i,
  input  wire logic [MAX_LENGTH_LOG2-1:0]      phase_i,
  output fca_ctl_t                             ctl_o,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_o,
  output logic signed [TWIDDLE_WIDTH-1:0]      cos_o,
  output logic signed [TWIDDLE_WIDTH-1:0]      sin_o
);

  localparam int TW_FRAC = TWIDDLE_WIDTH - 2;
  localparam int SH      = 30 - TW_FRAC;
  localparam logic signed [CW-1:0] ROUND_HALF = {{(CW-1){1'b0}}, 1'b1} << (SH - 1);
  localparam logic signed [CW-1:0] TW_ONE     = {{(CW-1){1'b0}}, 1'b1} << TW_FRAC;
  localparam logic signed [CW-1:0] TW_NEG_ONE = -TW_ONE;

  fca_ctl_t                       ctl_s    [CORDIC_STEPS+1];
  logic signed [SAMPLE_WIDTH-1:0] sample_s [CORDIC_STEPS+1];
  logic [1:0]                     quad_s   [CORDIC_STEPS+1];
  logic signed [CW-1:0]           x_s      [CORDIC_STEPS+1];
  logic signed [CW-1:0]           y_s      [CORDIC_STEPS+1];
  logic signed [ZW-1:0]           z_s      [CORDIC_STEPS+1];
  logic [29:0]                    z_frac;

  // The top two phase bits pick the quadrant; the rest is the angle within it.
  assign z_frac      = {phase_i[MAX_LENGTH_LOG2-3:0], {(32-MAX_LENGTH_LOG2){1'b0}}};
  assign ctl_s[0]    = ctl_i;
  assign sample_s[0] = sample_i;
  assign quad_s[0]   = phase_i[MAX_LENGTH_LOG2-1:MAX_LENGTH_LOG2-2];
  assign x_s[0]      = CORDIC_GAIN_INV;
  assign y_s[0]      = '0;
  assign z_s[0]      = {2'b00, z_frac};

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    fca_cordic_stage #(
      .STEP        (g),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_i),
      .ctl_i   (ctl_s[g]),
      .sample_i(sample_s[g]),
      .quad_i  (quad_s[g]),
      .x_i     (x_s[g]),
      .y_i     (y_s[g]),
      .z_i     (z_s[g]),
      .ctl_o   (ctl_s[g+1]),
      .sample_o(sample_s[g+1]),
      .quad_o  (quad_s[g+1]),
      .x_o     (x_s[g+1]),
      .y_o     (y_s[g+1]),
      .z_o     (z_s[g+1])
    );
  end

  function automatic logic signed [TWIDDLE_WIDTH-1:0] to_twiddle(
    input logic signed [CW-1:0] v
  );
    logic signed [CW-1:0] r;
    r = (v + ROUND_HALF) >>> SH;
    if (r > TW_ONE) begin
      r = TW_ONE;
    end else if (r < TW_NEG_ONE) begin
      r = TW_NEG_ONE;
    end
    return r[TWIDDLE_WIDTH-1:0];
  endfunction

  logic signed [TWIDDLE_WIDTH-1:0] cc, ss, cos_d, sin_d, cos_q, sin_q;
  fca_ctl_t                        ctl_q;
  logic signed [SAMPLE_WIDTH-1:0]  sample_q;

  always_comb begin
    cc = to_twiddle(x_s[CORDIC_STEPS]);
    ss = to_twiddle(y_s[CORDIC_STEPS]);
    case (quad_s[CORDIC_STEPS])
      2'd0: begin
        cos_d = cc;
        sin_d = ss;
      end
      2'd1: begin
        cos_d = -ss;
        sin_d = cc;
      end
      2'd2: begin
        cos_d = -cc;
        sin_d = -ss;
      end
      default: begin
        cos_d = ss;
        sin_d = -cc;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_s[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sample_q <= sample_s[CORDIC_STEPS];
      cos_q    <= cos_d;
      sin_q    <= sin_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;
  assign cos_o    = cos_q;
  assign sin_o    = sin_q;

endmodule

`default_nettype wire

// ===== rtl/core/fca_accum.sv =====
`default_nettype none

module fca_accum
  import fca_pkg::*;
#(
  parameter int MAX_LENGTH_LOG2 = 12,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int TWIDDLE_WIDTH   = 16
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      adv_i,
  input  wire fca_ctl_t                            ctl_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  input  wire logic signed [TWIDDLE_WIDTH-1:0]     cos_i,
  input  wire logic signed [TWIDDLE_WIDTH-1:0]     sin_i,
  input  wire                                      fin_take_i,
  output logic                                     hold_o,
  output logic                                     fin_valid_o,
  output logic signed [SAMPLE_WIDTH+TWIDDLE_WIDTH+MAX_LENGTH_LOG2-1:0] fin_cos_o,
  output logic signed [SAMPLE_WIDTH+TWIDDLE_WIDTH+MAX_LENGTH_LOG2-1:0] fin_sin_o,
  output logic signed [SAMPLE_WIDTH+MAX_LENGTH_LOG2:0]                 fin_plain_o
);

  localparam int PW   = SAMPLE_WIDTH + TWIDDLE_WIDTH;
  localparam int AW   = PW + MAX_LENGTH_LOG2;
  localparam int PS_W = SAMPLE_WIDTH + MAX_LENGTH_LOG2 + 1;

  fca_ctl_t                       pctl_q;
  logic signed [PW-1:0]           pc_q, ps_q;
  logic signed [SAMPLE_WIDTH-1:0] px_q;

  logic signed [AW-1:0]   cos_sum_q, cos_sum_d, sin_sum_q, sin_sum_d;
  logic signed [AW-1:0]   fin_cos_q, fin_sin_q;
  logic signed [PS_W-1:0] plain_sum_q, plain_sum_d, fin_plain_q;
  logic                   fin_valid_q, load;

  // Product register between the multipliers and the accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pctl_q <= '0;
    end else if (adv_i) begin
      pctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pc_q <= PW'(sample_i) * PW'(cos_i);
      ps_q <= PW'(sample_i) * PW'(sin_i);
      px_q <= sample_i;
    end
  end

  // A frame's last beat cannot leave while the previous frame's sums still wait.
  assign hold_o = pctl_q.valid && pctl_q.last && fin_valid_q && !fin_take_i;
  assign load   = adv_i && pctl_q.valid && pctl_q.last;

  assign cos_sum_d   = cos_sum_q + AW'(pc_q);
  assign sin_sum_d   = sin_sum_q + AW'(ps_q);
  assign plain_sum_d = plain_sum_q + PS_W'(px_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_sum_q   <= '0;
      sin_sum_q   <= '0;
      plain_sum_q <= '0;
      fin_valid_q <= 1'b0;
    end else begin
      if (adv_i && pctl_q.valid) begin
        if (pctl_q.last) begin
          cos_sum_q   <= '0;
          sin_sum_q   <= '0;
          plain_sum_q <= '0;
        end else begin
          cos_sum_q   <= cos_sum_d;
          sin_sum_q   <= sin_sum_d;
          plain_sum_q <= plain_sum_d;
        end
      end
      fin_valid_q <= load || (fin_valid_q && !fin_take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fin_cos_q   <= cos_sum_d;
      fin_sin_q   <= sin_sum_d;
      fin_plain_q <= plain_sum_d;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_cos_o   = fin_cos_q;
  assign fin_sin_o   = fin_sin_q;
  assign fin_plain_o = fin_plain_q;

endmodule

`default_nettype wire

// ===== rtl/core/fourier_coefficient_accumulator_unit.sv =====
`default_nettype none

// Single-bin DFT: accumulates the samples of one selected channel against the
// cosine and sine of harmonic n over a frame of 2^L samples, then emits one
// beat with an, bn (15 fraction bits) and the frame mean.
// Input stream: s_axis carries the sample in tdata and its channel in tuser.
// Beats of other channels are taken and dropped. Output stream: m_axis
// carries one beat per frame. Configuration writes go through cfg_we_i,
// cfg_idx_i and cfg_data_i and take effect at the next clock edge.
// Throughput is one beat per cycle while the input is not stalled. The path
// from the last beat of a frame to m_axis_tvalid runs through the 20-stage
// rotation pipeline that generates the twiddles, followed by rounding,
// multiply, accumulate and output register stages.
// While a result waits on m_axis_tready the pipeline keeps accepting beats;
// a second finished frame waits behind it, and the input stalls only when a
// third frame finishes before the first result has been taken.
// Reset clears the sums, the sample count, the phase and the pipeline, and
// loads n = 1, L = 8, channel 0.
module fourier_coefficient_accumulator_unit
  import fca_pkg::*;
#(
  parameter int MAX_LENGTH_LOG2 = 12,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int TWIDDLE_WIDTH   = 16
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]                    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]                   cfg_data_i,
  input  wire                                          s_axis_tvalid,
  output logic                                         s_axis_tready,
  // sample
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // sample_channel
  input  wire logic [CHANNEL_W-1:0]                    s_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  wire                                          m_axis_tready,
  // cos_coeff, sin_coeff, mean_value
  output logic [2*COEFF_W+MEAN_W-1:0]                  m_axis_tdata
);

  localparam int ML   = MAX_LENGTH_LOG2;
  localparam int LW   = $clog2(ML + 1);
  localparam int AW   = SAMPLE_WIDTH + TWIDDLE_WIDTH + ML;
  localparam int PS_W = SAMPLE_WIDTH + ML + 1;
  localparam int LMAX = (TWIDDLE_WIDTH < 17) ? (17 - TWIDDLE_WIDTH) : 0;
  localparam int BIAS = TWIDDLE_WIDTH - 18 + LMAX;
  localparam int SCW  = (AW + LMAX > COEFF_W + 1) ? (AW + LMAX) : (COEFF_W + 1);
  localparam int SHW  = $clog2(ML + TWIDDLE_WIDTH);
  localparam int MW   = (PS_W > MEAN_W) ? PS_W : MEAN_W;
  localparam logic [LW-1:0] ML_V = LW'(ML);
  localparam logic signed [SCW-1:0] SAT_MAX = {{(SCW-COEFF_W+1){1'b0}}, {(COEFF_W-1){1'b1}}};
  localparam logic signed [SCW-1:0] SAT_MIN = {{(SCW-COEFF_W+1){1'b1}}, {(COEFF_W-1){1'b0}}};

  // Configuration registers.
  logic [HARMONIC_W-1:0] harmonic_q;
  logic [LENGTH_W-1:0]   length_q;
  logic [CHANNEL_W-1:0]  channel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      harmonic_q <= HARMONIC_W'(1);
      length_q   <= LENGTH_W'(8);
      channel_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HARMONIC_INDEX: harmonic_q <= cfg_data_i[HARMONIC_W-1:0];
        CFG_LENGTH_LOG2:    length_q   <= cfg_data_i[LENGTH_W-1:0];
        CFG_CHANNEL_SELECT: channel_q  <= cfg_data_i[CHANNEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame length exponent.
  logic [LW-1:0] l_eff;

  always_comb begin
    if (length_q == '0) begin
      l_eff = LW'(1);
    end else if (int'(length_q) > ML) begin
      l_eff = ML_V;
    end else begin
      l_eff = LW'(length_q);
    end
  end

  // Frame position and phase of the next sample.
  logic [ML-1:0]            count_q, last_count, phase_q, phase_d;
  logic [HARMONIC_W+ML-1:0] step_wide;
  logic                     adv, match, accept, is_last;

  assign last_count = {ML{1'b1}} >> (ML_V - l_eff);
  assign is_last    = count_q >= last_count;
  assign step_wide  = (HARMONIC_W + ML)'(harmonic_q) << (ML_V - l_eff);
  assign phase_d    = phase_q + step_wide[ML-1:0];
  assign match      = s_axis_tuser == channel_q;
  assign accept     = s_axis_tvalid && s_axis_tready && match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= '0;
    end else if (accept) begin
      if (is_last) begin
        count_q <= '0;
        phase_q <= '0;
      end else begin
        count_q <= count_q + ML'(1);
        phase_q <= phase_d;
      end
    end
  end

  // Twiddle generation and accumulation.
  fca_ctl_t                        in_ctl, tw_ctl;
  logic signed [SAMPLE_WIDTH-1:0]  tw_sample;
  logic signed [TWIDDLE_WIDTH-1:0] tw_cos, tw_sin;
  logic                            hold, fin_valid, fin_take;
  logic signed [AW-1:0]            fin_cos, fin_sin;
  logic signed [PS_W-1:0]          fin_plain;

  assign in_ctl.valid  = s_axis_tvalid && match;
  assign in_ctl.last   = is_last;
  assign adv           = !hold;
  assign s_axis_tready = adv;

  fca_twiddle #(
    .MAX_LENGTH_LOG2(MAX_LENGTH_LOG2),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .TWIDDLE_WIDTH  (TWIDDLE_WIDTH)
  ) u_twiddle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (in_ctl),
    .sample_i(s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .phase_i (phase_q),
    .ctl_o   (tw_ctl),
    .sample_o(tw_sample),
    .cos_o   (tw_cos),
    .sin_o   (tw_sin)
  );

  fca_accum #(
    .MAX_LENGTH_LOG2(MAX_LENGTH_LOG2),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .TWIDDLE_WIDTH  (TWIDDLE_WIDTH)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .ctl_i      (tw_ctl),
    .sample_i   (tw_sample),
    .cos_i      (tw_cos),
    .sin_i      (tw_sin),
    .fin_take_i (fin_take),
    .hold_o     (hold),
    .fin_valid_o(fin_valid),
    .fin_cos_o  (fin_cos),
    .fin_sin_o  (fin_sin),
    .fin_plain_o(fin_plain)
  );

  // Scaling by 2/T with saturation, and the mean.
  function automatic logic [COEFF_W-1:0] scale_coeff(
    input logic signed [AW-1:0] sum,
    input logic [SHW-1:0]       sh
  );
    logic signed [SCW-1:0] w;
    w = SCW'(sum) <<< LMAX;
    w = w >>> sh;
    if (w > SAT_MAX) begin
      w = SAT_MAX;
    end else if (w < SAT_MIN) begin
      w = SAT_MIN;
    end
    return w[COEFF_W-1:0];
  endfunction

  logic [SHW-1:0]         coeff_sh;
  logic signed [MW-1:0]   mean_wide;
  logic                   out_valid_q;
  logic [2*COEFF_W+MEAN_W-1:0] out_data_q, out_data_d;

  assign coeff_sh   = SHW'(int'(l_eff) + BIAS);
  assign mean_wide  = MW'(fin_plain) >>> l_eff;
  assign out_data_d = {mean_wide[MEAN_W-1:0], scale_coeff(fin_sin, coeff_sh),
                       scale_coeff(fin_cos, coeff_sh)};
  assign fin_take   = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_take) begin
      out_valid_q <= fin_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take && fin_valid) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The phase always starts a frame at zero.
  a_phase_zero_at_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (phase_q == '0))
    else $error("phase not zero at frame start");

  // A frame's last beat resets the frame position.
  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_last) |=> (count_q == '0 && phase_q == '0))
    else $error("frame position not cleared after last beat");

  // A result only appears after finished sums were waiting for it.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(fin_valid))
    else $error("result without finished frame");

endmodule

`default_nettype wire
